// ----- design/kce_pkg.sv -----
// Shared types and constants for the k-combination enumerator.
// Used by kce_cfg_regs, kce_pos_mem, kce_seq and the top level; depends on nothing.
package kce_pkg;

    // Default sizes of the enumeration (largest k and largest n).
    localparam int MAX_K_DEF = 16;
    localparam int MAX_N_DEF = 64;

    // Field widths of the configuration registers and the result.
    localparam int K_W    = 5;
    localparam int N_W    = 7;
    localparam int ELEM_W = 6;

    // Configuration bus.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Register indexes.
    localparam logic REG_SUBSET_SIZE = 1'b0;
    localparam logic REG_SET_SIZE    = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_ELEM  = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_NONE  = 2'd2
    } t_status;

    // Configuration as seen by the sequencer.
    typedef struct packed {
        logic [K_W-1:0] subset_size;
        logic [N_W-1:0] set_size;
        logic           wr_strobe;
    } t_cfg;

endpackage

// ----- design/kce_cfg_regs.sv -----
// Configuration registers (subset size k, set size n) behind an APB-style port.
// Depends on kce_pkg.
module kce_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [kce_pkg::APB_AW-1:0]  paddr,
    input  logic [kce_pkg::APB_DW-1:0]  pwdata,
    output logic [kce_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output kce_pkg::t_cfg               o_cfg
);

    logic [kce_pkg::K_W-1:0] r_subset_size;
    logic [kce_pkg::N_W-1:0] r_set_size;
    logic                    wr_en;
    logic                    reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[2];

    // Register writes; any write restarts the enumeration through wr_strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_subset_size <= '0;
            r_set_size    <= '0;
        end else if (wr_en) begin
            if (reg_sel == kce_pkg::REG_SUBSET_SIZE) begin
                r_subset_size <= pwdata[kce_pkg::K_W-1:0];
            end else begin
                r_set_size <= pwdata[kce_pkg::N_W-1:0];
            end
        end
    end

    // Read data.
    always_comb begin
        if (reg_sel == kce_pkg::REG_SUBSET_SIZE) begin
            prdata = kce_pkg::APB_DW'(r_subset_size);
        end else begin
            prdata = kce_pkg::APB_DW'(r_set_size);
        end
    end

    assign o_cfg.subset_size = r_subset_size;
    assign o_cfg.set_size    = r_set_size;
    assign o_cfg.wr_strobe   = wr_en;

endmodule

// ----- design/kce_pos_mem.sv -----
// Position memory: one write port, one read port, registered read data.
// Depends on kce_pkg for the element width.
module kce_pos_mem #(
    parameter int DEPTH = kce_pkg::MAX_K_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [kce_pkg::ELEM_W-1:0]  i_wdata,
    input  logic                        i_re,
    input  logic [AW-1:0]               i_raddr,
    output logic [kce_pkg::ELEM_W-1:0]  o_rdata
);

    logic [kce_pkg::ELEM_W-1:0] r_mem [DEPTH];
    logic [kce_pkg::ELEM_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/kce_seq.sv -----
// Request sequencer: emits the current combination (the first is counted out, later
// ones come from the position memory), tracks the rightmost growable position, then
// writes back the refilled tail. Depends on kce_pkg; drives kce_pos_mem.
module kce_seq #(
    parameter int MAX_K = kce_pkg::MAX_K_DEF,
    parameter int AW    = (MAX_K > 1) ? $clog2(MAX_K) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  kce_pkg::t_cfg               i_cfg,
    input  logic                        i_req_valid,
    input  logic                        i_req_restart,
    output logic                        o_req_ready,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output logic [kce_pkg::ELEM_W-1:0]  o_res_element,
    output kce_pkg::t_status            o_res_status,
    output logic                        o_res_last,
    output logic                        o_res_final,
    output logic                        o_mem_we,
    output logic [AW-1:0]               o_mem_waddr,
    output logic [kce_pkg::ELEM_W-1:0]  o_mem_wdata,
    output logic                        o_mem_re,
    output logic [AW-1:0]               o_mem_raddr,
    input  logic [kce_pkg::ELEM_W-1:0]  i_mem_rdata
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SINGLE,
        ST_EMIT,
        ST_ADV
    } t_state;

    t_state                     r_state, n_state;
    logic                       r_exh, n_exh;
    logic                       r_emitted, n_emitted;
    logic                       r_first, n_first;
    logic                       r_fin, n_fin;
    logic [kce_pkg::N_W-1:0]    r_lim, n_lim;
    logic [AW-1:0]              r_idx, n_idx;
    logic [AW-1:0]              r_t, n_t;
    logic [kce_pkg::ELEM_W-1:0] r_pt, n_pt;
    logic [kce_pkg::ELEM_W-1:0] r_wv, n_wv;
    kce_pkg::t_status           r_single_status, n_single_status;
    logic                       r_single_final, n_single_final;
    logic                       r_ov, n_ov;
    logic [kce_pkg::ELEM_W-1:0] r_out_elem, n_out_elem;
    kce_pkg::t_status           r_out_status, n_out_status;
    logic                       r_out_last, n_out_last;
    logic                       r_out_final, n_out_final;

    logic [kce_pkg::K_W-1:0]    k;
    logic [kce_pkg::N_W-1:0]    n;
    logic                       out_free;
    logic                       none;
    logic                       eff_exh;
    logic                       eff_emitted;
    logic [kce_pkg::ELEM_W-1:0] cur_val;
    logic                       idx_last;
    logic                       fin_now;
    logic                       grow;

    assign k        = i_cfg.subset_size;
    assign n        = i_cfg.set_size;
    assign out_free = !r_ov || i_res_ready;

    // Request classification.
    assign none = (32'(k) > 32'(MAX_K)) || (32'(n) > 32'(kce_pkg::MAX_N_DEF)) ||
                  (kce_pkg::N_W'(k) > n);
    assign eff_exh     = r_exh & ~i_req_restart;
    assign eff_emitted = r_emitted & ~i_req_restart;

    // Current element: the first combination is 0..k-1, else it comes from memory.
    assign cur_val  = r_first ? kce_pkg::ELEM_W'(r_idx) : i_mem_rdata;
    assign idx_last = (8'(r_idx) + 8'd1) == 8'(k);
    assign fin_now  = (r_idx == '0) ? (8'(cur_val) == 8'(r_lim)) : r_fin;
    assign grow     = 8'(cur_val) != (8'(r_lim) + 8'(r_idx));

    assign o_req_ready = (r_state == ST_IDLE);

    // Next-state logic.
    always_comb begin
        n_state         = r_state;
        n_exh           = r_exh;
        n_emitted       = r_emitted;
        n_first         = r_first;
        n_fin           = r_fin;
        n_lim           = r_lim;
        n_idx           = r_idx;
        n_t             = r_t;
        n_pt            = r_pt;
        n_wv            = r_wv;
        n_single_status = r_single_status;
        n_single_final  = r_single_final;
        n_ov            = r_ov && !i_res_ready;
        n_out_elem      = r_out_elem;
        n_out_status    = r_out_status;
        n_out_last      = r_out_last;
        n_out_final     = r_out_final;
        o_mem_we        = 1'b0;
        o_mem_waddr     = r_idx;
        o_mem_wdata     = cur_val;
        o_mem_re        = 1'b0;
        o_mem_raddr     = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_exh     = eff_exh;
                    n_emitted = eff_emitted;
                    if (none || eff_exh) begin
                        n_single_status = kce_pkg::STATUS_NONE;
                        n_single_final  = 1'b0;
                        n_state         = ST_SINGLE;
                    end else if (k == '0) begin
                        n_single_status = kce_pkg::STATUS_EMPTY;
                        n_single_final  = 1'b1;
                        n_emitted       = 1'b1;
                        n_exh           = 1'b1;
                        n_state         = ST_SINGLE;
                    end else begin
                        n_first   = !eff_emitted;
                        n_lim     = n - kce_pkg::N_W'(k);
                        n_idx     = '0;
                        n_emitted = 1'b1;
                        o_mem_re  = 1'b1;
                        n_state   = ST_EMIT;
                    end
                end
            end
            ST_SINGLE: begin
                if (out_free) begin
                    n_ov         = 1'b1;
                    n_out_elem   = '0;
                    n_out_status = r_single_status;
                    n_out_last   = 1'b1;
                    n_out_final  = r_single_final;
                    n_state      = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_ov         = 1'b1;
                    n_out_elem   = cur_val;
                    n_out_status = kce_pkg::STATUS_ELEM;
                    n_out_last   = idx_last;
                    n_out_final  = fin_now;
                    n_fin        = fin_now;
                    // Keep the rightmost position that can still grow.
                    if (r_idx == '0) begin
                        n_t  = '0;
                        n_pt = cur_val;
                    end else if (grow) begin
                        n_t  = r_idx;
                        n_pt = cur_val;
                    end
                    // The first combination is stored as it goes out.
                    o_mem_we = r_first;
                    if (idx_last) begin
                        if (fin_now) begin
                            n_exh   = 1'b1;
                            n_state = ST_IDLE;
                        end else begin
                            n_idx   = n_t;
                            n_wv    = n_pt + kce_pkg::ELEM_W'(1);
                            n_state = ST_ADV;
                        end
                    end else begin
                        n_idx       = r_idx + AW'(1);
                        o_mem_re    = 1'b1;
                        o_mem_raddr = r_idx + AW'(1);
                    end
                end
            end
            ST_ADV: begin
                // Bump the growable position and refill the tail consecutively.
                o_mem_we    = 1'b1;
                o_mem_wdata = r_wv;
                if (idx_last) begin
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + AW'(1);
                    n_wv  = r_wv + kce_pkg::ELEM_W'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // A register write restarts the enumeration.
        if (i_cfg.wr_strobe) begin
            n_exh     = 1'b0;
            n_emitted = 1'b0;
        end
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_exh     <= 1'b0;
            r_emitted <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_exh     <= n_exh;
            r_emitted <= n_emitted;
            r_ov      <= n_ov;
        end
        r_first         <= n_first;
        r_fin           <= n_fin;
        r_lim           <= n_lim;
        r_idx           <= n_idx;
        r_t             <= n_t;
        r_pt            <= n_pt;
        r_wv            <= n_wv;
        r_single_status <= n_single_status;
        r_single_final  <= n_single_final;
        r_out_elem      <= n_out_elem;
        r_out_status    <= n_out_status;
        r_out_last      <= n_out_last;
        r_out_final     <= n_out_final;
    end

    assign o_res_valid   = r_ov;
    assign o_res_element = r_out_elem;
    assign o_res_status  = r_out_status;
    assign o_res_last    = r_out_last;
    assign o_res_final   = r_out_final;

`ifndef NO_ASSERTIONS
    // Reads and writes of the position memory never meet at one entry.
    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mem_we && o_mem_re) |-> (o_mem_waddr != o_mem_raddr))
        else $error("position memory read and write hit the same entry");

    // Status and empty results are single-result transactions.
    a_single_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && (r_out_status != kce_pkg::STATUS_ELEM)) |-> r_out_last)
        else $error("non-element result without last flag");

    // The write-back never runs past the k-th position.
    a_adv_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ADV) |-> (8'(r_idx) < 8'(k)))
        else $error("write-back index beyond subset size");

    // A finished enumeration is never advanced.
    a_no_adv_when_exh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ADV) |-> !r_exh)
        else $error("advance while exhausted");

    // The last result of a combination returns the sequencer to idle or write-back.
    a_last_leaves_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && out_free && idx_last) |=> (r_state != ST_EMIT))
        else $error("emission continued after the last element");
`endif

endmodule

// ----- design/k_combination_enumerator.sv -----
// Lexicographic k-combination enumerator. Each request on the slave stream
// returns the current k-element subset of {0..n-1} as k transactions, one index
// each in increasing order, with tlast on the final one, then steps to the next
// subset. A request is accepted in the idle state, where position 0 is read;
// then the indices are emitted at one index per cycle while the output is taken,
// then the bumped position t and the refilled tail are written back through the
// single write port of the position memory. The final combination needs no
// write-back. A new request is accepted only once the sequencer is idle again.
// Status results (empty, none, exhausted) are single transactions. The largest
// set size comes from the package, since the element field holds indices up to
// 63. Any register write restarts the enumeration. The position memory needs
// no clearing pass: its data is used only once the first combination is stored.
module k_combination_enumerator #(
    parameter int MAX_K = kce_pkg::MAX_K_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration port.
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [kce_pkg::APB_AW-1:0]  paddr,
    input  logic [kce_pkg::APB_DW-1:0]  pwdata,
    output logic [kce_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    // Request stream.
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,   // [0] restart, [7:1] zero
    // Result stream.
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [7:0]                  m_axis_tdata,   // [5:0] element, [7:6] status
    output logic                        m_axis_tlast,   // last_in_combination
    output logic                        m_axis_tuser    // [0] final_combination
);

    localparam int AW = (MAX_K > 1) ? $clog2(MAX_K) : 1;

    kce_pkg::t_cfg              cfg;
    kce_pkg::t_status           res_status;
    logic [kce_pkg::ELEM_W-1:0] res_element;
    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    logic [kce_pkg::ELEM_W-1:0] mem_wdata;
    logic                       mem_re;
    logic [AW-1:0]              mem_raddr;
    logic [kce_pkg::ELEM_W-1:0] mem_rdata;

    // Configuration registers.
    kce_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Position memory.
    kce_pos_mem #(
        .DEPTH (MAX_K),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Request sequencer.
    kce_seq #(
        .MAX_K (MAX_K),
        .AW    (AW)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_req_valid   (s_axis_tvalid),
        .i_req_restart (s_axis_tdata[0]),
        .o_req_ready   (s_axis_tready),
        .o_res_valid   (m_axis_tvalid),
        .i_res_ready   (m_axis_tready),
        .o_res_element (res_element),
        .o_res_status  (res_status),
        .o_res_last    (m_axis_tlast),
        .o_res_final   (m_axis_tuser),
        .o_mem_we      (mem_we),
        .o_mem_waddr   (mem_waddr),
        .o_mem_wdata   (mem_wdata),
        .o_mem_re      (mem_re),
        .o_mem_raddr   (mem_raddr),
        .i_mem_rdata   (mem_rdata)
    );

    assign m_axis_tdata = {res_status, res_element};

endmodule
